@@ hdl/rrts_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rrts_pkg
// shared types, codes and sizes of the round-robin task scheduler
// ---------------------------------------------------------------------------
package rrts_pkg;

	localparam int SLOT_W    = 4;
	localparam int MAX_TASKS = 1 << SLOT_W;
	localparam int ACT_W     = 4;
	localparam int DEPTH_W   = 8;
	localparam int STATE_W   = 2;
	localparam int STEP_W    = $clog2(MAX_TASKS + 1);

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [STATE_W-1:0] slot_st_t;

	// scheduler events
	localparam logic [ACT_W-1:0] ACT_TICK    = 4'd0;
	localparam logic [ACT_W-1:0] ACT_YIELD   = 4'd1;
	localparam logic [ACT_W-1:0] ACT_BLOCK   = 4'd2;
	localparam logic [ACT_W-1:0] ACT_UNBLOCK = 4'd3;
	localparam logic [ACT_W-1:0] ACT_CREATE  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_EXIT    = 4'd5;
	localparam logic [ACT_W-1:0] ACT_PRE_OFF = 4'd6;
	localparam logic [ACT_W-1:0] ACT_PRE_ON  = 4'd7;
	localparam logic [ACT_W-1:0] ACT_SWITCH  = 4'd8;

	// per-slot task state
	localparam slot_st_t SS_FREE    = 2'd0;
	localparam slot_st_t SS_READY   = 2'd1;
	localparam slot_st_t SS_RUNNING = 2'd2;
	localparam slot_st_t SS_BLOCKED = 2'd3;

	localparam depth_t DEPTH_MAX = '1;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOFREE = 2'd1,
		STAT_HALT   = 2'd2,
		STAT_DEFER  = 2'd3
	} rrts_status_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		slot_t            target_slot;
	} rrts_ev_t;

	typedef struct packed {
		slot_t        current_slot;
		logic         switched;
		slot_t        new_slot;
		rrts_status_t status;
	} rrts_res_t;

endpackage
`default_nettype wire

@@ hdl/rrts_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rrts_ram
// generic one-write one-read ram, registered read, old data on collision
// ---------------------------------------------------------------------------
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/rrts_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rrts_ctrl
// event sequencer over the slot-state, ring and preemption-depth rams
// ---------------------------------------------------------------------------
module rrts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rrts_pkg::rrts_ev_t ev,
	output logic                   idle,
	output logic                   res_vld,
	input  wire logic              res_take,
	output rrts_pkg::rrts_res_t    res
);

	import rrts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_WALK,
		S_EXIT_WALK,
		S_EXIT2,
		S_LINK,
		S_SW2,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [ACT_W-1:0] act_q;
	slot_t            tgt_q;
	slot_t            running_q;
	logic             halted_q;
	logic [MAX_TASKS-1:0] free_q;
	logic [MAX_TASKS-1:0] st_vld_q;
	logic [MAX_TASKS-1:0] nx_vld_q;
	logic [MAX_TASKS-1:0] dp_vld_q;
	slot_st_t         cur_st_q;
	slot_t            n_q;
	slot_t            succ_q;
	logic [STEP_W-1:0] step_q;
	slot_t            new_slot_q;
	logic             switched_q;
	rrts_status_t     status_q;
	slot_t            ra_q;

	// ram ports
	slot_t    ra;
	logic     st_we, nx_we, dp_we;
	slot_t    st_wa, nx_wa, dp_wa;
	slot_st_t st_wd, st_rdata, st_rd;
	slot_t    nx_wd, nx_rdata, nx_rd;
	depth_t   dp_wd, dp_rdata, dp_rd;

	slot_t cur;
	slot_t free_idx;
	logic  free_any;
	logic  walk_self, walk_ready, walk_end;
	logic  exit_found, exit_end;

	rrts_ram #(.WIDTH(STATE_W), .DEPTH(MAX_TASKS)) u_st_ram (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(ra), .rdata(st_rdata)
	);

	rrts_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_TASKS)) u_nx_ram (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(ra), .rdata(nx_rdata)
	);

	rrts_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_TASKS)) u_dp_ram (
		.clk(clk), .we(dp_we), .waddr(dp_wa), .wdata(dp_wd), .raddr(ra), .rdata(dp_rdata)
	);

	// entries never written read as their reset value
	assign st_rd = st_vld_q[ra_q] ? st_rdata : ((ra_q == '0) ? SS_RUNNING : SS_FREE);
	assign nx_rd = nx_vld_q[ra_q] ? nx_rdata : '0;
	assign dp_rd = dp_vld_q[ra_q] ? dp_rdata : '0;

	assign cur = running_q;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end
	assign free_any = |free_q;

	assign walk_self  = (n_q == cur);
	assign walk_ready = (st_rd == SS_READY);
	assign walk_end   = (step_q == STEP_W'(MAX_TASKS));
	assign exit_found = (nx_rd == cur);
	assign exit_end   = (step_q == STEP_W'(MAX_TASKS - 1));

	// read address and write ports
	always_comb begin
		ra    = running_q;
		st_we = 1'b0;
		st_wa = cur;
		st_wd = SS_FREE;
		nx_we = 1'b0;
		nx_wa = cur;
		nx_wd = '0;
		dp_we = 1'b0;
		dp_wa = cur;
		dp_wd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ra = (ev.action == ACT_UNBLOCK) ? ev.target_slot : running_q;
					if (!halted_q && ev.action == ACT_BLOCK) begin
						st_we = 1'b1;
						st_wd = SS_BLOCKED;
					end
				end
			end
			S_FIRST: begin
				ra = nx_rd;
				case (act_q)
					ACT_UNBLOCK: begin
						if (st_rd == SS_BLOCKED) begin
							st_we = 1'b1;
							st_wa = tgt_q;
							st_wd = SS_READY;
						end
					end
					ACT_CREATE: begin
						nx_we = 1'b1;
						nx_wa = free_idx;
						nx_wd = nx_rd;
						st_we = 1'b1;
						st_wa = free_idx;
						st_wd = SS_READY;
						dp_we = 1'b1;
						dp_wa = free_idx;
						dp_wd = '0;
					end
					ACT_PRE_OFF: begin
						if (dp_rd != DEPTH_MAX) begin
							dp_we = 1'b1;
							dp_wd = dp_rd + DEPTH_W'(1);
						end
					end
					ACT_PRE_ON: begin
						if (dp_rd != '0) begin
							dp_we = 1'b1;
							dp_wd = dp_rd - DEPTH_W'(1);
						end
					end
					ACT_SWITCH: begin
						if (tgt_q != cur && !free_q[tgt_q] && st_rd == SS_RUNNING) begin
							st_we = 1'b1;
							st_wd = SS_READY;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				ra = nx_rd;
				if (walk_self || (!walk_ready && walk_end)) begin
					if (cur_st_q == SS_READY) begin
						st_we = 1'b1;
						st_wd = SS_RUNNING;
					end
				end else if (walk_ready) begin
					if (cur_st_q == SS_RUNNING) begin
						st_we = 1'b1;
						st_wd = SS_READY;
					end
				end
			end
			S_EXIT_WALK: begin
				ra = nx_rd;
				if (exit_found && n_q != cur) begin
					nx_we = 1'b1;
					nx_wa = n_q;
					nx_wd = succ_q;
					st_we = 1'b1;
					st_wd = SS_FREE;
					dp_we = 1'b1;
					dp_wd = '0;
				end
			end
			S_EXIT2: begin
				nx_we = 1'b1;
				nx_wd = '0;
				st_we = 1'b1;
				st_wa = succ_q;
				st_wd = SS_RUNNING;
			end
			S_LINK: begin
				nx_we = 1'b1;
				nx_wd = new_slot_q;
			end
			S_SW2: begin
				st_we = 1'b1;
				st_wa = tgt_q;
				st_wd = SS_RUNNING;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			act_q      <= ACT_TICK;
			tgt_q      <= '0;
			running_q  <= '0;
			halted_q   <= 1'b0;
			free_q     <= ~MAX_TASKS'(1);
			st_vld_q   <= '0;
			nx_vld_q   <= '0;
			dp_vld_q   <= '0;
			cur_st_q   <= SS_FREE;
			n_q        <= '0;
			succ_q     <= '0;
			step_q     <= '0;
			new_slot_q <= '0;
			switched_q <= 1'b0;
			status_q   <= STAT_OK;
			ra_q       <= '0;
		end else begin
			ra_q <= ra;
			if (st_we) begin
				st_vld_q[st_wa] <= 1'b1;
			end
			if (nx_we) begin
				nx_vld_q[nx_wa] <= 1'b1;
			end
			if (dp_we) begin
				dp_vld_q[dp_wa] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q      <= ev.action;
						tgt_q      <= ev.target_slot;
						switched_q <= 1'b0;
						new_slot_q <= '0;
						status_q   <= STAT_OK;
						if (halted_q) begin
							status_q <= STAT_HALT;
							state_q  <= S_DONE;
						end else begin
							case (ev.action)
								ACT_TICK, ACT_YIELD, ACT_UNBLOCK, ACT_EXIT,
								ACT_PRE_OFF, ACT_PRE_ON, ACT_SWITCH: begin
									state_q <= S_FIRST;
								end
								ACT_BLOCK: begin
									cur_st_q <= SS_BLOCKED;
									state_q  <= S_FIRST;
								end
								ACT_CREATE: begin
									if (free_any) begin
										state_q <= S_FIRST;
									end else begin
										status_q <= STAT_NOFREE;
										state_q  <= S_DONE;
									end
								end
								default: begin
									state_q <= S_DONE;
								end
							endcase
						end
					end
				end
				S_FIRST: begin
					case (act_q)
						ACT_TICK, ACT_YIELD, ACT_BLOCK: begin
							if (act_q == ACT_TICK && dp_rd != '0) begin
								status_q <= STAT_DEFER;
								state_q  <= S_DONE;
							end else begin
								if (act_q != ACT_BLOCK) begin
									cur_st_q <= st_rd;
								end
								n_q     <= nx_rd;
								step_q  <= '0;
								state_q <= S_WALK;
							end
						end
						ACT_EXIT: begin
							succ_q <= nx_rd;
							if (nx_rd == cur) begin
								halted_q <= 1'b1;
								status_q <= STAT_HALT;
								state_q  <= S_DONE;
							end else begin
								n_q     <= nx_rd;
								step_q  <= STEP_W'(1);
								state_q <= S_EXIT_WALK;
							end
						end
						ACT_CREATE: begin
							new_slot_q       <= free_idx;
							free_q[free_idx] <= 1'b0;
							state_q          <= S_LINK;
						end
						ACT_SWITCH: begin
							if (tgt_q != cur && !free_q[tgt_q]) begin
								state_q <= S_SW2;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_WALK: begin
					if (walk_self || (!walk_ready && walk_end)) begin
						state_q <= S_DONE;
					end else if (walk_ready) begin
						tgt_q   <= n_q;
						state_q <= S_SW2;
					end else begin
						n_q    <= nx_rd;
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_EXIT_WALK: begin
					if (exit_found) begin
						if (n_q == cur) begin
							halted_q <= 1'b1;
							status_q <= STAT_HALT;
							state_q  <= S_DONE;
						end else begin
							free_q[cur] <= 1'b1;
							state_q     <= S_EXIT2;
						end
					end else if (exit_end) begin
						halted_q <= 1'b1;
						status_q <= STAT_HALT;
						state_q  <= S_DONE;
					end else begin
						n_q    <= nx_rd;
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_EXIT2: begin
					running_q  <= succ_q;
					switched_q <= 1'b1;
					state_q    <= S_DONE;
				end
				S_LINK: begin
					state_q <= S_DONE;
				end
				S_SW2: begin
					running_q  <= tgt_q;
					switched_q <= 1'b1;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle             = (state_q == S_IDLE);
	assign res_vld          = (state_q == S_DONE);
	assign res.current_slot = running_q;
	assign res.switched     = switched_q;
	assign res.new_slot     = new_slot_q;
	assign res.status       = status_q;

	// the running task never sits on a free slot between events
	a_run_not_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !free_q[running_q])
		else $error("running slot is marked free");

	// halt is final
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag dropped");

	// walks are bounded by the table size
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(MAX_TASKS))
		else $error("ring walk ran past the table");

	// a deferred tick or a failed create never changes the running task
	a_no_switch_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && (status_q == STAT_DEFER || status_q == STAT_NOFREE)) |-> !switched_q)
		else $error("switch reported with deferred tick or failed create");

endmodule
`default_nettype wire

@@ hdl/round_robin_task_scheduler.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// round_robin_task_scheduler
// task-slot table with a ring order, slot states and preemption depth
// ---------------------------------------------------------------------------
// Takes one scheduler event per beat on the event channel and answers with
// one beat on the result channel. Slot state, ring links and preemption
// depth live in three small rams with registered reads; a sequencer reads,
// updates and writes them back. Events are handled one at a time: simple
// events (unblock, preemption on or off, switch, create) finish without a
// ring walk; tick, yield and block walk the ring one slot a cycle through
// the ring ram's read port; exit searches the ring for the predecessor the
// same way. No clearing pass is needed after reset: unwritten ram entries
// read as their reset values. A result waits in an output register, so the
// next event is taken while the previous result is still stalled. Once the
// last task exits the block stays halted and answers every event with
// status 2.
// ---------------------------------------------------------------------------
module round_robin_task_scheduler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// event channel
	input  wire logic                        event_valid,
	output logic                             event_stall,
	input  wire logic [rrts_pkg::ACT_W-1:0]  action,
	input  wire rrts_pkg::slot_t             target_slot,
	// result channel
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output rrts_pkg::slot_t                  current_slot,
	output logic                             switched,
	output rrts_pkg::slot_t                  new_slot,
	output logic [1:0]                       status
);

	import rrts_pkg::*;

	logic      ctrl_idle;
	logic      res_vld;
	logic      res_take;
	rrts_ev_t  ev;
	rrts_res_t res;
	rrts_res_t out_q;
	logic      out_full_q;
	logic      ev_beat;

	// new events only while the sequencer is idle
	assign event_stall = !ctrl_idle;
	assign ev_beat     = event_valid && !event_stall;

	assign ev.action      = action;
	assign ev.target_slot = target_slot;

	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ev_beat),
		.ev       (ev),
		.idle     (ctrl_idle),
		.res_vld  (res_vld),
		.res_take (res_take),
		.res      (res)
	);

	// output register: loads when empty or being drained this cycle
	assign res_take = res_vld && (!out_full_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
			out_q      <= '0;
		end else begin
			if (res_take) begin
				out_full_q <= 1'b1;
				out_q      <= res;
			end else if (!result_stall) begin
				out_full_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_full_q;
	assign current_slot = out_q.current_slot;
	assign switched     = out_q.switched;
	assign new_slot     = out_q.new_slot;
	assign status       = 2'(out_q.status);

endmodule
`default_nettype wire
